### rtl/core/srb_pkg.sv
// Shared types and codes for the stream ring buffer with offsets.
`timescale 1ns / 1ps
`default_nettype none
package srb_pkg;

   localparam int FUNC_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 12;
   localparam int COUNT_W  = 13;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_APPEND,
      FN_PEEK,
      FN_REMOVE,
      FN_WRITE_AT,
      FN_POP
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK,
      STAT_RANGE,
      STAT_EMPTY
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [BYTE_W-1:0]   data_byte;
      logic [OFFSET_W-1:0] offset;
      logic [COUNT_W-1:0]  amount;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   read_byte;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  amount_done;
      logic [COUNT_W-1:0]  fill_level;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

### rtl/core/srb_ctrl.sv
// Controller state machine: sequences accept, execute and result load.
`timescale 1ns / 1ps
`default_nettype none
module srb_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   output srb_pkg::ctrl_cmd_type  cmd,
   input  srb_pkg::dp_status_type sts
);
   import srb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_stall     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall     = reset;
            cmd.load_item = req_valid && !reset;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/srb_datapath.sv
// Datapath: byte store, indices, fill count, size register and output register.
`timescale 1ns / 1ps
`default_nettype none
module srb_datapath #(
   parameter int DEPTH = 4096
) (
   input  wire                              clock,
   input  wire                              reset,
   input  srb_pkg::req_type                 req_word,
   output srb_pkg::rsp_type                 rsp_word,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [srb_pkg::COUNT_W-1:0]       csr_wdata,
   input  srb_pkg::ctrl_cmd_type            cmd,
   output srb_pkg::dp_status_type           sts
);
   import srb_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] step,
                                              input logic [AW-1:0] lim);
      logic [AW-1:0] s;
      s = base + step;
      if (s >= lim) begin
         s = s - lim;
      end
      return s;
   endfunction

   req_type           item_ff;
   logic [CW-1:0]     used_ff;
   logic [IW-1:0]     wr_idx_ff;
   logic [IW-1:0]     rd_idx_ff;
   logic [CW-1:0]     fill_ff;
   logic [BYTE_W-1:0] store_ff [DEPTH];
   logic [BYTE_W-1:0] mem_q_ff;
   logic [STATUS_W-1:0] pend_status_ff;
   logic [CW-1:0]     pend_done_ff;
   logic [CW-1:0]     pend_fill_ff;
   logic              pend_rd_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_word_ff;

   logic [IW-1:0]     wr_idx_in;
   logic [IW-1:0]     rd_idx_in;
   logic [CW-1:0]     fill_in;
   logic [STATUS_W-1:0] status_in;
   logic [CW-1:0]     done_in;
   logic              rd_flag_in;
   logic              mem_we;
   logic              mem_re;
   logic [IW-1:0]     mem_addr;

   logic [AW-1:0]     used_w;
   logic [AW-1:0]     fill_w;
   logic [AW-1:0]     free_w;
   logic [AW-1:0]     off_w;
   logic [AW-1:0]     amt_w;
   logic [AW-1:0]     done_w;
   logic [AW-1:0]     pos_w;
   logic [AW-1:0]     cfg_w;
   logic [CW-1:0]     cfg_used;
   logic              cfg_we;

   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid & csr_ready;
   assign cfg_w     = AW'(csr_wdata);

   always_comb begin
      if (cfg_w == '0) begin
         cfg_used = CW'(1);
      end else if (cfg_w > AW'(DEPTH)) begin
         cfg_used = CW'(DEPTH);
      end else begin
         cfg_used = CW'(cfg_w);
      end
   end

   assign used_w = AW'(used_ff);
   assign fill_w = AW'(fill_ff);
   assign free_w = used_w - fill_w;
   assign off_w  = AW'(item_ff.offset);
   assign amt_w  = AW'(item_ff.amount);
   assign done_w = (amt_w > fill_w) ? fill_w : amt_w;
   assign pos_w  = wrap_add(AW'(wr_idx_ff), off_w, used_w);

   always_comb begin
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      fill_in    = fill_ff;
      status_in  = STAT_OK;
      done_in    = '0;
      rd_flag_in = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = wr_idx_ff;
      case (item_ff.func)
         FN_APPEND: begin
            if (fill_w < used_w) begin
               mem_we    = 1'b1;
               wr_idx_in = IW'(wrap_add(AW'(wr_idx_ff), AW'(1), used_w));
               fill_in   = CW'(fill_w + AW'(1));
            end else begin
               status_in = STAT_RANGE;
            end
         end
         FN_PEEK: begin
            if (fill_ff == '0) begin
               status_in = STAT_EMPTY;
            end else if (off_w < fill_w) begin
               mem_re     = 1'b1;
               rd_flag_in = 1'b1;
               mem_addr   = IW'(wrap_add(AW'(rd_idx_ff), off_w, used_w));
            end else begin
               status_in = STAT_RANGE;
            end
         end
         FN_REMOVE: begin
            done_in   = CW'(done_w);
            rd_idx_in = IW'(wrap_add(AW'(rd_idx_ff), done_w, used_w));
            fill_in   = CW'(fill_w - done_w);
         end
         FN_WRITE_AT: begin
            if (off_w < free_w) begin
               mem_we    = 1'b1;
               mem_addr  = IW'(pos_w);
               wr_idx_in = IW'(wrap_add(pos_w, AW'(1), used_w));
               fill_in   = CW'(fill_w + AW'(1));
            end else begin
               status_in = STAT_RANGE;
            end
         end
         FN_POP: begin
            if (fill_ff == '0) begin
               status_in = STAT_EMPTY;
            end else begin
               mem_re     = 1'b1;
               rd_flag_in = 1'b1;
               mem_addr   = rd_idx_ff;
               rd_idx_in  = IW'(wrap_add(AW'(rd_idx_ff), AW'(1), used_w));
               fill_in    = CW'(fill_w - AW'(1));
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_word;
      end
      if (cmd.exec) begin
         pend_status_ff <= status_in;
         pend_done_ff   <= done_in;
         pend_fill_ff   <= fill_in;
         pend_rd_ff     <= rd_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && mem_we) begin
         store_ff[mem_addr] <= item_ff.data_byte;
      end
      if (cmd.exec && mem_re) begin
         mem_q_ff <= store_ff[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= CW'(DEPTH);
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
      end else if (cfg_we) begin
         used_ff   <= cfg_used;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
      end else if (cmd.exec) begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_word_ff.read_byte   <= pend_rd_ff ? mem_q_ff : '0;
         rsp_word_ff.status      <= pend_status_ff;
         rsp_word_ff.amount_done <= COUNT_W'(pend_done_ff);
         rsp_word_ff.fill_level  <= COUNT_W'(pend_fill_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

endmodule
`default_nettype wire

### rtl/core/stream_ring_buffer_with_offsets.sv
// Top level of the stream ring buffer with offsets.
`timescale 1ns / 1ps
`default_nettype none
// Byte ring buffer of DEPTH bytes, of which csr_wdata selects how many are in
// use (0 reads as 1, values above DEPTH as DEPTH); any size write also empties
// the buffer. Each request word is one operation (append, peek at offset,
// remove, write at offset, pop) and yields one response word. A word passes
// through S_IDLE, which captures the request, S_EXEC, which updates the
// indices and accesses the store through a registered read, and S_RESULT,
// which loads the response register once it is free; rsp_valid is registered
// from that load. A response register still held by rsp_stall delays the
// load. The next request is taken right after the load, while the response
// still waits on rsp_stall. Both input channels are held off during reset.
// Store bytes are not cleared by reset.
module stream_ring_buffer_with_offsets #(
   parameter int DEPTH = 4096
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  srb_pkg::req_type           req_word,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output srb_pkg::rsp_type           rsp_word,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [srb_pkg::COUNT_W-1:0] csr_wdata
);
   import srb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;
   logic          dp_csr_ready;

   assign csr_ready = dp_csr_ready & !reset;

   srb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   srb_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (dp_csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.exec)
      else $error("accepted word not executed");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("response overwritten while stalled");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded response not presented");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == STAT_EMPTY) |->
         (rsp_word.read_byte == '0 && rsp_word.fill_level == '0 &&
          rsp_word.amount_done == '0))
      else $error("empty status with nonzero fields");

endmodule
`default_nettype wire

### sim/stream_ring_buffer_with_offsets_test.sv
// Testbench for the byte ring buffer with offsets, checked word by word against a predictor.
`timescale 1ns / 1ps
module stream_ring_buffer_with_offsets_test;
   import srb_pkg::*;

   localparam int RING_DEPTH  = 4096;
   localparam int LATENCY_PAD = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_W-1:0] csr_wdata = '0;

   // predictor state
   logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
   bit ring_seen [RING_DEPTH];
   int model_wr, model_rd, model_fill;
   int model_size = RING_DEPTH;

   rsp_type pending_rsp [$];
   int err_count = 0;
   int cycle_count = 0;
   bit gaps_on = 1'b1;
   int burst_left = 0;
   int hold_req = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   stream_ring_buffer_with_offsets u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int ring_wrap(input int base, input int step);
      int s;
      s = base + step;
      if (s >= model_size) s -= model_size;
      return s;
   endfunction

   function automatic void ring_apply(input req_type w, output rsp_type r);
      int pos;
      int done;
      r = '0;
      case (w.func)
         FN_APPEND: begin
            if (model_fill < model_size) begin
               ring_mem[model_wr] = w.data_byte;
               ring_seen[model_wr] = 1'b1;
               model_wr = ring_wrap(model_wr, 1);
               model_fill++;
            end else r.status = STAT_RANGE;
         end
         FN_PEEK: begin
            if (model_fill == 0) r.status = STAT_EMPTY;
            else if (w.offset < model_fill) r.read_byte = ring_mem[ring_wrap(model_rd, w.offset)];
            else r.status = STAT_RANGE;
         end
         FN_REMOVE: begin
            done = (w.amount > model_fill) ? model_fill : int'(w.amount);
            model_rd = ring_wrap(model_rd, done);
            model_fill -= done;
            r.amount_done = COUNT_W'(done);
         end
         FN_WRITE_AT: begin
            if (w.offset < model_size - model_fill) begin
               pos = ring_wrap(model_wr, w.offset);
               ring_mem[pos] = w.data_byte;
               ring_seen[pos] = 1'b1;
               model_wr = ring_wrap(pos, 1);
               model_fill++;
            end else r.status = STAT_RANGE;
         end
         FN_POP: begin
            if (model_fill == 0) r.status = STAT_EMPTY;
            else begin
               r.read_byte = ring_mem[model_rd];
               model_rd = ring_wrap(model_rd, 1);
               model_fill--;
            end
         end
         default: ;
      endcase
      r.fill_level = COUNT_W'(model_fill);
   endfunction

   // store entries never written since reset must not be read back
   function automatic bit reads_unseen(input req_type w);
      if (model_fill == 0) return 1'b0;
      if (w.func == FN_POP) return !ring_seen[model_rd];
      if (w.func == FN_PEEK && w.offset < model_fill)
         return !ring_seen[ring_wrap(model_rd, w.offset)];
      return 1'b0;
   endfunction

   function automatic req_type make_word(input logic [FUNC_W-1:0] f, input int data,
                                         input int off, input int amt);
      req_type w;
      w.func = f;
      w.data_byte = BYTE_W'(data);
      w.offset = OFFSET_W'(off);
      w.amount = COUNT_W'(amt);
      return w;
   endfunction

   function automatic req_type rand_word();
      req_type w;
      int pick, free, top;
      w.func = FN_APPEND;
      w.data_byte = BYTE_W'($urandom);
      w.offset = OFFSET_W'($urandom);
      w.amount = COUNT_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) w.func = FN_APPEND;
      else if (pick < 50) begin
         w.func = FN_PEEK;
         if (model_fill > 0 && $urandom_range(0, 4) != 0)
            w.offset = OFFSET_W'($urandom_range(0, model_fill - 1));
      end else if (pick < 58) begin
         w.func = FN_REMOVE;
         if ($urandom_range(0, 4) != 0) w.amount = COUNT_W'($urandom_range(0, 3));
      end else if (pick < 72) begin
         w.func = FN_WRITE_AT;
         free = model_size - model_fill;
         if (free > 0 && $urandom_range(0, 3) != 0) begin
            top = (free > 4) ? 3 : free - 1;
            w.offset = OFFSET_W'($urandom_range(0, top));
         end
      end else if (pick < 96) w.func = FN_POP;
      else w.func = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      return w;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      err_count++;
      if (err_count <= 100)
         $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
   endtask

   task automatic push_word(input req_type w);
      rsp_type r;
      int gap;
      if (reads_unseen(w)) w.func = FN_APPEND;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      ring_apply(w, r);
      pending_rsp.push_back(r);
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   task automatic write_size(input int value);
      logic [COUNT_W-1:0] v;
      v = COUNT_W'(value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_size = (v == 0) ? 1 : (v > RING_DEPTH) ? RING_DEPTH : int'(v);
      model_wr = 0;
      model_rd = 0;
      model_fill = 0;
   endtask

   // receive side: long hold-offs on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end else mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            2: rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= (cycle_count % 4 == 0);
         endcase
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) report("unexpected word", rsp_word, '0);
         else begin
            want = pending_rsp.pop_front();
            if (rsp_word.read_byte !== want.read_byte)
               report("read_byte", rsp_word.read_byte, want.read_byte);
            if (rsp_word.status !== want.status)
               report("status", rsp_word.status, want.status);
            if (rsp_word.amount_done !== want.amount_done)
               report("amount_done", rsp_word.amount_done, want.amount_done);
            if (rsp_word.fill_level !== want.fill_level)
               report("fill_level", rsp_word.fill_level, want.fill_level);
         end
      end
   end

   task automatic test_basic_ops();
      push_word(make_word(FN_POP, 8'h3C, 0, 0));
      push_word(make_word(FN_PEEK, 0, 4095, 0));
      push_word(make_word(FN_REMOVE, 0, 0, 8191));
      push_word(make_word(FN_APPEND, 8'h00, 0, 0));
      push_word(make_word(FN_APPEND, 8'hFF, 4095, 8191));
      push_word(make_word(FN_PEEK, 0, 0, 0));
      push_word(make_word(FN_PEEK, 0, 2, 0));
      push_word(make_word(FN_WRITE_AT, 8'h5A, 4094, 0));
      push_word(make_word(FN_WRITE_AT, 8'hA5, 4093, 0));
      push_word(make_word(FN_POP, 0, 0, 0));
      push_word(make_word(FN_REMOVE, 0, 0, 8191));
      push_word(make_word(FN_UNUSED_LO, 8'hFF, 4095, 8191));
      push_word(make_word(FN_UNUSED_HI, 8'h81, 1, 4096));
   endtask

   task automatic test_size_extremes();
      write_size(0);
      push_word(make_word(FN_APPEND, 8'h11, 0, 0));
      push_word(make_word(FN_APPEND, 8'h22, 0, 0));
      push_word(make_word(FN_WRITE_AT, 8'h33, 0, 0));
      push_word(make_word(FN_PEEK, 0, 1, 0));
      push_word(make_word(FN_POP, 0, 0, 0));
      push_word(make_word(FN_WRITE_AT, 8'h44, 0, 0));
      write_size(8191);
      push_word(make_word(FN_APPEND, 8'h55, 0, 0));
      push_word(make_word(FN_POP, 0, 0, 0));
      write_size(2);
      push_word(make_word(FN_APPEND, 8'h66, 0, 0));
      push_word(make_word(FN_APPEND, 8'h77, 0, 0));
      push_word(make_word(FN_POP, 0, 0, 0));
      push_word(make_word(FN_APPEND, 8'h88, 0, 0));
      push_word(make_word(FN_PEEK, 0, 1, 0));
   endtask

   task automatic test_random_phases();
      int sizes [9] = '{7, 4096, 1, 16, 3, 300, 8191, 0, 2};
      foreach (sizes[p]) begin
         write_size(sizes[p]);
         repeat (100) push_word(rand_word());
      end
      write_size($urandom_range(1, 8191));
      repeat (100) push_word(rand_word());
   endtask

   task automatic test_backpressure();
      write_size(32);
      gaps_on = 1'b0;
      hold_req = 300;
      repeat (80) push_word(rand_word());
      gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic test_pause_resume();
      write_size(4096);
      repeat (40) push_word(rand_word());
      wait_idle();
      repeat (40) push_word(rand_word());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_size_extremes();
      test_random_phases();
      test_backpressure();
      test_pause_resume();
      wait_idle();
      repeat (LATENCY_PAD) @(posedge clock);
      if (pending_rsp.size() != 0) report("words missing", pending_rsp.size(), 0);
      if (err_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
rtl/core/srb_pkg.sv
rtl/core/srb_ctrl.sv
rtl/core/srb_datapath.sv
rtl/core/stream_ring_buffer_with_offsets.sv
sim/stream_ring_buffer_with_offsets_test.sv
